FILE: hw/rtl/ssf_pkg.sv
// Shared types, constants and code points for the seven-segment text framer.
package ssf_pkg;

  localparam int DIGITS = 4;
  localparam int POS_W = 3;
  localparam int IDX_W = $clog2(DIGITS + 3);
  localparam int COLON_DIGIT = 1;

  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_9 = 8'h39;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_COLON = 8'h3a;

  localparam logic [7:0] CMD_WRITE = 8'h40;
  localparam logic [7:0] CMD_ADDRESS = 8'hc0;
  localparam logic [7:0] CMD_CONTROL = 8'h80;
  localparam logic [3:0] CTRL_ON = 4'h8;
  localparam logic [3:0] MAX_LEVEL = 4'd8;
  localparam logic [7:0] MINUS_SEGMENTS = 8'h40;
  localparam logic [7:0] COLON_BIT = 8'h80;

  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       frame_last;
  } out_item_t;

  // Digit 0 sits in the low byte.
  typedef logic [DIGITS-1:0][7:0] frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/seven_segment_text_framer_top.sv
// Top level of the seven-segment text framer: front end, frame queue, byte sequencer.
// One character is taken per clock while the frame queue has room. A character marked
// end_of_text closes the text into a frame of DIGITS+3 bus bytes, which the sequencer
// hands out one byte per pop; the two-entry frame queue lets text for the next frame
// come in while a frame drains, and in_full rises only when two finished frames wait
// behind the one being sent.
module seven_segment_text_framer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ssf_pkg::in_item_t   in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output ssf_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [3:0]          cfg_data
);

  logic               accept;
  logic               frame_push;
  ssf_pkg::frame_t    frame_data;
  ssf_pkg::frame_t    q_data;
  ssf_pkg::q_status_t q_status;
  logic               q_pop;
  logic [3:0]         brightness_r;

  assign cfg_ready = 1'b1;
  assign in_full   = q_status.full;
  assign accept    = in_push && !q_status.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      brightness_r <= cfg_data;
    end
  end

  ssf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_item),
    .frame_push (frame_push),
    .frame_data (frame_data)
  );

  ssf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (frame_push),
    .push_data (frame_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  ssf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_status.empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .brightness (brightness_r),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule

FILE: hw/rtl/ssf_front.sv
// Front end: takes characters, builds the digit store and hands finished frames on.
module ssf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  ssf_pkg::in_item_t   item,
  output logic                frame_push,
  output ssf_pkg::frame_t     frame_data
);

  logic [ssf_pkg::POS_W-1:0] pos_r, pos_nxt;
  ssf_pkg::frame_t           store_r, store_nxt;
  logic                      align_r, align_nxt;
  logic [ssf_pkg::POS_W-1:0] shift;
  logic [3:0]                seg_idx;

  assign seg_idx = 4'(item.char_code - ssf_pkg::ASCII_0);

  always_comb begin
    store_nxt = store_r;
    pos_nxt   = pos_r;
    align_nxt = align_r;
    if (pos_r < ssf_pkg::POS_W'(ssf_pkg::DIGITS)) begin
      case (item.char_code) inside
        [ssf_pkg::ASCII_0:ssf_pkg::ASCII_9]: begin
          for (int d = 0; d < ssf_pkg::DIGITS; d++) begin
            if (ssf_pkg::POS_W'(d) == pos_r) store_nxt[d] = ssf_pkg::DIGIT_SEG[seg_idx];
          end
          pos_nxt = pos_r + 1'b1;
        end
        ssf_pkg::ASCII_MINUS: begin
          for (int d = 0; d < ssf_pkg::DIGITS; d++) begin
            if (ssf_pkg::POS_W'(d) == pos_r) store_nxt[d] = ssf_pkg::MINUS_SEGMENTS;
          end
          pos_nxt = pos_r + 1'b1;
        end
        ssf_pkg::ASCII_COLON: begin
          // set the colon bit on digit COLON_DIGIT and go on at position 2 without right-alignment
          for (int d = 0; d < ssf_pkg::DIGITS; d++) begin
            if (d == ssf_pkg::COLON_DIGIT) store_nxt[d] = store_r[d] | ssf_pkg::COLON_BIT;
          end
          pos_nxt   = ssf_pkg::POS_W'(2);
          align_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // right-align: move digits up by the number of unused positions
  assign shift = ssf_pkg::POS_W'(ssf_pkg::DIGITS) - pos_nxt;

  always_comb begin
    if (align_nxt && (pos_nxt < ssf_pkg::POS_W'(ssf_pkg::DIGITS))) begin
      frame_data = ssf_pkg::frame_t'(store_nxt << {shift, 3'b000});
    end else begin
      frame_data = store_nxt;
    end
  end

  assign frame_push = accept && item.end_of_text;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      store_r <= '0;
      align_r <= 1'b1;
    end else if (accept) begin
      if (item.end_of_text) begin
        pos_r   <= '0;
        store_r <= '0;
        align_r <= 1'b1;
      end else begin
        pos_r   <= pos_nxt;
        store_r <= store_nxt;
        align_r <= align_nxt;
      end
    end
  end

endmodule

FILE: hw/rtl/ssf_queue.sv
// Two-entry frame queue between the front end and the byte sequencer.
module ssf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ssf_pkg::frame_t     push_data,
  input  logic                pop,
  output ssf_pkg::frame_t     pop_data,
  output ssf_pkg::q_status_t  status
);

  ssf_pkg::frame_t entry_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 2'd1;
    else if (do_pop && !do_push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/ssf_back.sv
// Byte sequencer: walks one frame out as command, data and control bytes.
module ssf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  ssf_pkg::frame_t     q_data,
  output logic                q_pop,
  input  logic [3:0]          brightness,
  output logic                out_empty,
  input  logic                out_pop,
  output ssf_pkg::out_item_t  out_item
);

  localparam logic [ssf_pkg::IDX_W-1:0] FIRST_DATA = ssf_pkg::IDX_W'(2);
  localparam logic [ssf_pkg::IDX_W-1:0] LAST_DATA  = ssf_pkg::IDX_W'(ssf_pkg::DIGITS + 1);
  localparam logic [ssf_pkg::IDX_W-1:0] CTRL_IDX   = ssf_pkg::IDX_W'(ssf_pkg::DIGITS + 2);

  logic                      busy_r, busy_nxt;
  logic [ssf_pkg::IDX_W-1:0] idx_r, idx_nxt;
  ssf_pkg::frame_t           frame_r;
  logic                      adv, fin;
  logic [3:0]                level;
  logic [7:0]                ctrl_byte;
  logic [7:0]                data_byte;

  assign level = (brightness > ssf_pkg::MAX_LEVEL) ? ssf_pkg::MAX_LEVEL : brightness;
  assign ctrl_byte = ssf_pkg::CMD_CONTROL |
                     ((level != 4'd0) ? {4'd0, ssf_pkg::CTRL_ON + level - 4'd1} : 8'd0);

  always_comb begin
    data_byte = '0;
    for (int d = 0; d < ssf_pkg::DIGITS; d++) begin
      if (idx_r == ssf_pkg::IDX_W'(d + 2)) data_byte = frame_r[d];
    end
  end

  always_comb begin
    out_item = '0;
    if (idx_r == '0) begin
      out_item.bus_byte     = ssf_pkg::CMD_WRITE;
      out_item.start_before = 1'b1;
      out_item.stop_after   = 1'b1;
    end else if (idx_r == ssf_pkg::IDX_W'(1)) begin
      out_item.bus_byte     = ssf_pkg::CMD_ADDRESS;
      out_item.start_before = 1'b1;
    end else if (idx_r >= FIRST_DATA && idx_r <= LAST_DATA) begin
      out_item.bus_byte   = data_byte;
      out_item.stop_after = (idx_r == LAST_DATA);
    end else begin
      out_item.bus_byte     = ctrl_byte;
      out_item.start_before = 1'b1;
      out_item.stop_after   = 1'b1;
      out_item.frame_last   = 1'b1;
    end
  end

  assign out_empty = !busy_r;
  assign adv   = busy_r && out_pop;
  assign fin   = adv && (idx_r == CTRL_IDX);
  // next frame loads right behind the control byte of the previous one
  assign q_pop = !q_empty && (!busy_r || fin);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end else if (adv) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) frame_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule
